// ----- sv/ccorr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccorr_pkg
// Shared types and codes for the circular 2-D correlation unit: request and
// result records, request and status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package ccorr_pkg;

  localparam int PIXEL_W = 16;   // pixel Q8.8 and coefficient Q2.14 width
  localparam int COORD_W = 8;    // row and column field width
  localparam int CFG_W   = 9;    // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_SHIFT = 14;  // Q10.22 product sum down to Q8.8

  typedef enum logic [1:0] {
    REQ_COEF    = 2'd0,
    REQ_PIXEL   = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_SAT   = 2'd1,
    STAT_RANGE = 2'd2
  } status_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_KERNEL_SIZE  = 2'd2
  } cfg_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } seq_state_t;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic signed [PIXEL_W-1:0] data_value;
  } in_t;

  typedef struct packed {
    logic signed [PIXEL_W-1:0] out_value;
    logic [1:0]                status;
  } out_t;

endpackage

// ----- sv/circular_2d_correlation_unit.sv -----
// ----------------------------------------------------------------------------
// circular_2d_correlation_unit
// Frame and kernel store with one shared multiply-accumulate that works out a
// wrap-around 2-D correlation at a requested pixel, rounded and saturated.
// ----------------------------------------------------------------------------
// A compute request steps the window back to its corner, sweeps the taps,
//   drains the pipeline and shows its rounded result; busy falls as done rises.
//   Writes do not make the unit busy. No request is taken while a compute is
//   in flight; the single multiply-accumulate takes one tap per cycle. An
//   out-of-range compute answers in the next cycle. The receiver cannot stall.
// Reset (rst, synchronous): kernel zero, 256x256 frame, 3x3 kernel, idle.
module circular_2d_correlation_unit
  import ccorr_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_KERNEL = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  request,
  output logic                 done,
  output out_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Derived sizes
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FAW   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int KDEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int KAW   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KIW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KSW   = $clog2(MAX_KERNEL + 1);
  localparam int ACC_W = 2 * PIXEL_W + $clog2(KDEPTH);

  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (FRAC_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] RND_MAX  = ACC_W'((1 << (PIXEL_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] RND_MIN  = -ACC_W'(1 << (PIXEL_W - 1));

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [2:0]       kernel_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
      kernel_size  <= 3'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_KERNEL_SIZE:  kernel_size  <= cfg_data[2:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Effective frame size: zero acts as one, anything beyond the store clamps.
  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [KSW-1:0] eff_ks;
  logic [KSW-1:0] pad;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
    // Even sizes round up to the next odd size, then clamp to the store.
    if (32'(kernel_size | 3'd1) > MAX_KERNEL) begin
      eff_ks = KSW'(MAX_KERNEL);
    end else begin
      eff_ks = KSW'(kernel_size | 3'd1);
    end
    pad = eff_ks >> 1;
  end

  // --------------------------------------------------------------------------
  // Request decode
  // --------------------------------------------------------------------------
  logic accept;
  logic coord_ok;
  logic coef_ok;
  logic coef_wr;
  logic pixel_wr;
  logic compute_go;
  logic compute_oob;

  assign accept   = start && !busy && !rst;
  assign coord_ok = (32'(request.row) < 32'(eff_h)) && (32'(request.col) < 32'(eff_w));
  assign coef_ok  = (32'(request.row) < MAX_KERNEL) && (32'(request.col) < MAX_KERNEL);

  assign coef_wr     = accept && (request.req_type == REQ_COEF) && coef_ok;
  assign pixel_wr    = accept && (request.req_type == REQ_PIXEL) && coord_ok;
  assign compute_go  = accept && (request.req_type == REQ_COMPUTE) && coord_ok;
  assign compute_oob = accept && (request.req_type == REQ_COMPUTE) && !coord_ok;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  seq_state_t state;
  seq_state_t state_next;

  logic [KSW-1:0] cnt;     // pre-steps left to move the window to its corner
  logic [RW-1:0]  r;       // current frame row of the window
  logic [CW-1:0]  c;       // current frame column of the window
  logic [CW-1:0]  c0;      // window's left column, reloaded into c at each kernel row
  logic [KIW-1:0] ki;
  logic [KIW-1:0] kj;
  logic           issue;
  logic           last_tap;
  logic           s1;      // RAM read data valid
  logic           s2;      // product valid

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (compute_go) state_next = ST_SETUP;
      ST_SETUP: if (cnt == '0) state_next = ST_MAC;
      ST_MAC:   if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (!s1) state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != ST_IDLE);
    issue    = (state == ST_MAC);
    last_tap = issue && (ki == KIW'(eff_ks - 1'b1)) && (kj == KIW'(eff_ks - 1'b1));
  end

  // Window walk: step back by pad with wrap, then sweep row by row.
  always_ff @(posedge clk) begin
    if (compute_go) begin
      r   <= RW'(request.row);
      c   <= CW'(request.col);
      cnt <= pad;
      ki  <= '0;
      kj  <= '0;
    end else if (state == ST_SETUP) begin
      if (cnt != '0) begin
        r   <= (r == '0) ? RW'(eff_h - 1'b1) : r - 1'b1;
        c   <= (c == '0) ? CW'(eff_w - 1'b1) : c - 1'b1;
        cnt <= cnt - 1'b1;
      end else begin
        c0 <= c;
      end
    end else if (issue) begin
      if (kj == KIW'(eff_ks - 1'b1)) begin
        kj <= '0;
        ki <= ki + 1'b1;
        c  <= c0;
        r  <= (r == RW'(eff_h - 1'b1)) ? '0 : r + 1'b1;
      end else begin
        kj <= kj + 1'b1;
        c  <= (c == CW'(eff_w - 1'b1)) ? '0 : c + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stores
  // --------------------------------------------------------------------------
  logic [FAW-1:0]            frame_waddr;
  logic [FAW-1:0]            frame_raddr;
  logic [KAW-1:0]            kern_waddr;
  logic [KAW-1:0]            kern_raddr;
  logic [PIXEL_W-1:0]        frame_rdata;
  logic [PIXEL_W-1:0]        kern_rdata;
  logic [KDEPTH-1:0]         kvalid;
  logic                      kvalid_q;

  assign frame_waddr = FAW'(int'(request.row) * MAX_WIDTH + int'(request.col));
  assign frame_raddr = FAW'(int'(r) * MAX_WIDTH + int'(c));
  assign kern_waddr  = KAW'(int'(request.row) * MAX_KERNEL + int'(request.col));
  assign kern_raddr  = KAW'(int'(ki) * MAX_KERNEL + int'(kj));

  ccorr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (pixel_wr),
    .waddr (frame_waddr),
    .wdata (request.data_value),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  ccorr_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (KDEPTH)
  ) u_kern_ram (
    .clk   (clk),
    .we    (coef_wr),
    .waddr (kern_waddr),
    .wdata (request.data_value),
    .raddr (kern_raddr),
    .rdata (kern_rdata)
  );

  // Kernel entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
    end else if (coef_wr) begin
      kvalid[kern_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    kvalid_q <= kvalid[kern_raddr];
  end

  // --------------------------------------------------------------------------
  // Shared multiply-accumulate
  // --------------------------------------------------------------------------
  logic signed [PIXEL_W-1:0]   coef;
  logic signed [2*PIXEL_W-1:0] prod;
  logic signed [ACC_W-1:0]     acc;

  assign coef = kvalid_q ? $signed(kern_rdata) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= 1'b0;
      s2 <= 1'b0;
    end else begin
      s1 <= issue;
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(frame_rdata) * coef;
    if (compute_go) begin
      acc <= '0;
    end else if (s2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // --------------------------------------------------------------------------
  // Round half up to Q8.8, saturate, and present the result with a one-cycle done strobe
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0] rsum;
  logic signed [ACC_W-1:0] rnd;
  out_t                    res_next;

  always_comb begin
    rsum = acc + RND_BIAS;
    rnd  = rsum >>> FRAC_SHIFT;
    if (rnd > RND_MAX) begin
      res_next.out_value = PIXEL_W'(RND_MAX);
      res_next.status    = STAT_SAT;
    end else if (rnd < RND_MIN) begin
      res_next.out_value = PIXEL_W'(RND_MIN);
      res_next.status    = STAT_SAT;
    end else begin
      res_next.out_value = PIXEL_W'(rnd);
      res_next.status    = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_OUT) || compute_oob;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      result <= res_next;
    end else if (compute_oob) begin
      result.out_value <= '0;
      result.status    <= STAT_RANGE;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> (done && !busy))
    else $error("result strobe missing after final rounding step");

  a_oob_status: assert property (@(posedge clk) disable iff (rst)
    compute_oob |=> (done && (result.status == STAT_RANGE) && (result.out_value == '0)))
    else $error("out-of-range compute did not answer with range status");

  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!s1 && !s2))
    else $error("multiply-accumulate pipeline busy while idle");

  a_tap_count: assert property (@(posedge clk) disable iff (rst)
    (issue && !last_tap) |=> issue)
    else $error("tap sweep left before the last kernel tap");

endmodule

// ----- sv/ccorr_ram.sv -----
// ----------------------------------------------------------------------------
// ccorr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ccorr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
